// ===== design/gregorian_date_add_days_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date adder
// Shared forms for the port-level checks.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GDAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Widths, calendar constants and shared types of the Gregorian date adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 16;
  localparam int COUNT_W = 16;
  localparam int ALU_W   = 16;

  // Restoring division of the year by 100: quotient fits in 10 bits.
  localparam int DIV_STEPS = 10;
  localparam int DIV_K_W   = 4;
  localparam logic [ALU_W-1:0] DIV_UNIT = 16'd100;
  localparam logic [6:0] LAST_YEAR_OF_CENTURY = 7'd99;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_FEB_L = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB_C = 5'd28;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

  // Month codes outside 1..12 count as 31-day months.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (mon)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      MON_FEB: len = leap ? LEN_FEB_L : LEN_FEB_C;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

// ===== design/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Gregorian date plus a day count, one month per step on a shared subtractor.
// ----------------------------------------------------------------------------
// One date at a time. After a beat is taken, the shared subtractor divides
// the year by 100 to seed the leap-year tracking, then the same
// subtractor consumes one calendar month per cycle until the count is
// spent; a finish state then loads the output register, holding while it
// is still full and stalled. in_stall stays high while an item is in
// flight; a finished result waits in the output register and the next
// date can be taken meanwhile. Only the low CntW bits of days_to_add
// count: DAY_COUNT_BITS, capped at COUNT_W.
`timescale 1ns / 1ps

module gregorian_date_add_days #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gdad_pkg::DAY_W-1:0]     in_start_day,
  input  logic [gdad_pkg::MON_W-1:0]     in_start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [gdad_pkg::COUNT_W-1:0]   in_days_to_add,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gdad_pkg::DAY_W-1:0]     out_result_day,
  output logic [gdad_pkg::MON_W-1:0]     out_result_month,
  output logic [gdad_pkg::YEAR_W-1:0]    out_result_year,
  output logic                           out_year_overflow
);
  import gdad_pkg::*;

  localparam int CntW = (DAY_COUNT_BITS < COUNT_W) ? DAY_COUNT_BITS : COUNT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_STEP, ST_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MON_W-1:0]    mon_r, mon_nxt;
  logic [YEAR_W-1:0]   yr_r, yr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [ALU_W-1:0]    rem_r, rem_nxt;
  logic [1:0]          cent_r, cent_nxt;
  logic [DIV_K_W-1:0]  divk_r, divk_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]    out_day_r, out_day_nxt;
  logic [MON_W-1:0]    out_mon_r, out_mon_nxt;
  logic [YEAR_W-1:0]   out_yr_r, out_yr_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                leap;
  logic [DAY_W-1:0]    len;
  logic                short_mo;
  logic [DAY_W:0]      used;
  logic [ALU_W-1:0]    opnd_a, opnd_b;
  alu_res_t            alu;

  gdad_alu u_alu (
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .res    (alu)
  );

  // rem_r holds year mod 100 and cent_r the century mod 4 once the division is done.
  assign leap     = (yr_r[1:0] == 2'b00) && ((rem_r[6:0] != 7'd0) || (cent_r == 2'b00));
  assign len      = month_len(mon_r, leap);
  assign short_mo = day_r < len;
  assign used     = short_mo ? ((DAY_W+1)'(len) - (DAY_W+1)'(day_r) + (DAY_W+1)'(1))
                             : (DAY_W+1)'(1);

  assign opnd_a = (state_r == ST_DIV) ? rem_r : ALU_W'(cnt_r);
  assign opnd_b = (state_r == ST_DIV) ? (DIV_UNIT << divk_r) : ALU_W'(used);

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    yr_nxt        = yr_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    cent_nxt      = cent_r;
    divk_nxt      = divk_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_day_nxt   = out_day_r;
    out_mon_nxt   = out_mon_r;
    out_yr_nxt    = out_yr_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          day_nxt   = in_start_day;
          mon_nxt   = in_start_month;
          yr_nxt    = in_start_year;
          cnt_nxt   = in_days_to_add[CntW-1:0];
          rem_nxt   = in_start_year;
          cent_nxt  = 2'b00;
          divk_nxt  = DIV_K_W'(DIV_STEPS - 1);
          ovf_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!alu.borrow) begin
          rem_nxt = alu.diff;
        end
        // keep the two low quotient bits: century mod 4
        cent_nxt = {cent_r[0], !alu.borrow};
        if (divk_r == '0) begin
          state_nxt = ST_STEP;
        end else begin
          divk_nxt = divk_r - DIV_K_W'(1);
        end
      end
      ST_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else if (short_mo && alu.borrow) begin
          // count ends inside this month
          day_nxt = day_r + cnt_r[DAY_W-1:0];
          cnt_nxt = '0;
        end else begin
          cnt_nxt = alu.diff[CntW-1:0];
          day_nxt = DAY_W'(1);
          if (mon_r >= MON_DEC) begin
            mon_nxt = MON_JAN;
            if (yr_r == '1) begin
              yr_nxt   = '0;
              ovf_nxt  = 1'b1;
              rem_nxt  = '0;
              cent_nxt = 2'b00;
            end else begin
              yr_nxt = yr_r + YEAR_W'(1);
              if (rem_r[6:0] == LAST_YEAR_OF_CENTURY) begin
                rem_nxt  = '0;
                cent_nxt = cent_r + 2'd1;
              end else begin
                rem_nxt = ALU_W'(rem_r[6:0] + 7'd1);
              end
            end
          end else begin
            mon_nxt = mon_r + MON_W'(1);
          end
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = day_r;
          out_mon_nxt   = mon_r;
          out_yr_nxt    = yr_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    day_r     <= day_nxt;
    mon_r     <= mon_nxt;
    yr_r      <= yr_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    cent_r    <= cent_nxt;
    divk_r    <= divk_nxt;
    ovf_r     <= ovf_nxt;
    out_day_r <= out_day_nxt;
    out_mon_r <= out_mon_nxt;
    out_yr_r  <= out_yr_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_day    = out_day_r;
  assign out_result_month  = out_mon_r;
  assign out_result_year   = out_yr_r;
  assign out_year_overflow = out_ovf_r;

endmodule

// ===== design/gdad_alu.sv =====
// ----------------------------------------------------------------------------
// gdad_alu
// Shared subtractor with borrow; serves both the year division and the
// month-by-month day count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdad_alu (
  input  logic [gdad_pkg::ALU_W-1:0] opnd_a,
  input  logic [gdad_pkg::ALU_W-1:0] opnd_b,
  output gdad_pkg::alu_res_t         res
);
  import gdad_pkg::*;

  logic [ALU_W:0] wide;

  assign wide       = {1'b0, opnd_a} - {1'b0, opnd_b};
  assign res.diff   = wide[ALU_W-1:0];
  assign res.borrow = wide[ALU_W];

endmodule

// ===== design/gdad_checker.sv =====
// ----------------------------------------------------------------------------
// gdad_checker
// Port-level checks of the Gregorian date adder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_date_add_days_macros.svh"

module gdad_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [gdad_pkg::DAY_W-1:0]     out_result_day,
  input logic [gdad_pkg::MON_W-1:0]     out_result_month,
  input logic [gdad_pkg::YEAR_W-1:0]    out_result_year,
  input logic                           out_year_overflow
);
  import gdad_pkg::*;

  logic                          in_beat;
  logic                          out_held;
  logic [DAY_W+MON_W+YEAR_W:0]   out_bus;

  assign in_beat  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_bus  = {out_result_day, out_result_month, out_result_year, out_year_overflow};

  // a taken date keeps the input closed on the next cycle
  `GDAD_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall, "input open right after a beat")

  // a result never appears the cycle after a date is taken
  `GDAD_ASSERT_NEXT(a_no_instant_result, in_beat, !$rose(out_valid), "result too early")

  // a new result lands as the block goes idle
  `GDAD_ASSERT_NOW(a_result_at_idle, $rose(out_valid), !in_stall, "result while busy")

  // a stalled result holds its value
  `GDAD_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_bus), "stalled result changed")

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (.*);
